### sv/apid_pkg.sv
package apid_pkg;
    localparam int unsigned W = 32;
    typedef logic signed [W-1:0] t_q;

    localparam logic [1:0] REG_COV_INIT      = 2'd0;
    localparam logic [1:0] REG_FORGET_FACTOR = 2'd1;
    localparam logic [1:0] REG_FILTER_GAIN   = 2'd2;

    localparam logic [30:0] COV_INIT_RST = 31'd6554;
    localparam logic [16:0] FORGET_RST   = 17'd65536;
    localparam t_q          FGAIN_RST    = 32'sd65536;
    localparam t_q          QMAX         = 32'sh7fffffff;
    localparam t_q          QMIN         = -32'sh7fffffff - 32'sd1;

    // saturate a 64-bit signed value to 32 bits
    function automatic t_q sat64(input logic signed [63:0] v);
        t_q r;
        r = v[31:0];
        if (v > 64'sh000000007fffffff) r = QMAX;
        else if (v < -64'sh0000000080000000) r = QMIN;
        return r;
    endfunction

    function automatic t_q qadd(input t_q a, input t_q b);
        logic signed [32:0] s;
        t_q r;
        s = 33'(a) + 33'(b);
        r = s[31:0];
        if (s > 33'sh07fffffff) r = QMAX;
        else if (s < -33'sh080000000) r = QMIN;
        return r;
    endfunction

    function automatic t_q qsub(input t_q a, input t_q b);
        logic signed [32:0] s;
        t_q r;
        s = 33'(a) - 33'(b);
        r = s[31:0];
        if (s > 33'sh07fffffff) r = QMAX;
        else if (s < -33'sh080000000) r = QMIN;
        return r;
    endfunction
endpackage

### sv/adaptive_pid_gain_rls_update.sv
// the first four items skip the rls update; every later item runs it, with 18 divides on
// the shared divider (9 for the correction term, 9 for the scaling by lambda)
// one item at a time: input stall high from acceptance to output transfer
// reset (synchronous, active low): gains, history, step count zero; covariance
// cov_init on the diagonal; registers to their reset values
module adaptive_pid_gain_rls_update
    import apid_pkg::*;
#(
    parameter int FILTER_LEN = 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_q          i_err,
    input  t_q          i_err_integral,
    input  t_q          i_err_derivative,
    input  t_q          i_prev_control,
    output logic        o_valid,
    input  logic        i_stall,
    output t_q          o_control,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int HL  = (FILTER_LEN + 1) * 3;
    localparam int HLW = $clog2(HL);

    typedef enum logic [3:0] {
        S_IDLE, S_FILT, S_V, S_GAM, S_TDIV, S_TSUB, S_PDIV, S_E, S_G, S_GAIN,
        S_Y, S_OUT
    } t_state;

    t_state      r_state;
    logic [30:0] r_cov_init;
    logic [16:0] r_lam;
    t_q          r_fg;
    t_q          r_gain [3];
    t_q          r_p    [9];
    t_q          r_uh   [FILTER_LEN];
    t_q          r_rh   [HL];
    logic [2:0]  r_steps;
    t_q          r_phik [3];
    t_q          r_phi  [3];
    t_q          r_v    [3];
    t_q          r_w    [3];
    t_q          r_g    [3];
    t_q          r_uf;
    t_q          r_err;
    t_q          r_gam;
    t_q          r_e;
    t_q          r_acc;
    t_q          r_tmp;
    logic [3:0]  r_i;    // outer index (row / element / matrix entry)
    logic [1:0]  r_k;    // dot product term
    logic        r_dbusy;

    // single shared multiplier, inputs selected by the sequencer
    t_q               mul_a, mul_b, mul_q;
    logic signed [63:0] prod;
    logic             div_start, div_done;
    t_q               div_num, div_den, div_q;
    logic [1:0]       ri, rj;

    always_comb begin
        prod  = 64'(mul_a) * 64'(mul_b) + 64'sd32768;
        mul_q = sat64(prod >>> 16);
        // row and column of matrix entry r_i
        ri    = (r_i >= 4'd6) ? 2'd2 : (r_i >= 4'd3) ? 2'd1 : 2'd0;
        rj    = 2'(r_i - 4'(ri) * 4'd3);
    end

    always_comb begin
        mul_a = r_fg;
        mul_b = r_uh[FILTER_LEN-1];
        unique case (r_state)
            S_FILT: begin
                mul_a = r_fg;
                mul_b = (r_i == 0) ? r_uh[FILTER_LEN-1]
                                   : r_rh[HLW'(FILTER_LEN*3 + int'(r_i) - 1)];
            end
            S_V: begin
                // rows first (v), then columns (w)
                mul_a = r_phi[r_k];
                mul_b = (r_i < 3) ? r_p[4'(r_i * 4'd3 + 4'(r_k))]
                                  : r_p[4'(4'(r_k) * 4'd3 + r_i - 4'd3)];
            end
            S_GAM:  begin mul_a = r_phi[r_k]; mul_b = r_v[r_k]; end
            S_TDIV: begin mul_a = r_v[ri];    mul_b = r_w[rj]; end
            S_E:    begin mul_a = r_phi[r_k]; mul_b = r_gain[r_k]; end
            S_G:    begin mul_a = r_p[4'(r_i * 4'd3 + 4'(r_k))]; mul_b = r_phi[r_k]; end
            S_GAIN: begin mul_a = r_g[r_i[1:0]]; mul_b = r_e; end
            S_Y:    begin mul_a = r_phik[r_k]; mul_b = r_gain[r_k]; end
            default: ;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = r_tmp;
        div_den   = t_q'({15'd0, r_lam});
        if ((r_state == S_TDIV || r_state == S_PDIV) && !r_dbusy) div_start = 1'b1;
        if (r_state == S_TDIV) begin
            div_num = mul_q;
            div_den = r_gam;
        end
    end

    apid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cov_init <= COV_INIT_RST;
            r_lam      <= FORGET_RST;
            r_fg       <= FGAIN_RST;
            r_steps    <= '0;
            r_dbusy    <= 1'b0;
            o_valid    <= 1'b0;
            for (int n = 0; n < 3; n++) r_gain[n] <= '0;
            for (int n = 0; n < 9; n++)
                r_p[n] <= (n % 4 == 0) ? t_q'({1'b0, COV_INIT_RST}) : '0;
            for (int n = 0; n < FILTER_LEN; n++) r_uh[n] <= '0;
            for (int n = 0; n < HL; n++) r_rh[n] <= '0;
        end else begin
            // configuration is to be written only while idle; the block itself does not enforce this
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_COV_INIT: begin
                        r_cov_init <= i_cfg_data[30:0];
                        for (int n = 0; n < 9; n++)
                            r_p[n] <= (n % 4 == 0) ? t_q'({1'b0, i_cfg_data[30:0]}) : '0;
                    end
                    REG_FORGET_FACTOR: r_lam <= i_cfg_data[16:0];
                    REG_FILTER_GAIN:   r_fg  <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_err     <= i_err;
                        r_phik[0] <= i_err;
                        r_phik[1] <= i_err_integral;
                        r_phik[2] <= i_err_derivative;
                        for (int n = FILTER_LEN - 1; n > 0; n--) r_uh[n] <= r_uh[n-1];
                        r_uh[0] <= i_prev_control;
                        for (int n = HL - 1; n > 2; n--) r_rh[n] <= r_rh[n-3];
                        r_rh[0] <= i_err;
                        r_rh[1] <= i_err_integral;
                        r_rh[2] <= i_err_derivative;
                        r_i     <= '0;
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    // filtered control, then filtered regressor
                    if (r_i == 0) r_uf <= mul_q;
                    else r_phi[r_i[1:0] - 2'd1] <= mul_q;
                    r_i <= r_i + 4'd1;
                    r_k <= '0;
                    r_acc <= '0;
                    if (r_i == 4'd3) begin
                        r_i     <= '0;
                        r_state <= (r_steps >= 3'd4) ? S_V : S_Y;
                    end
                end
                S_V: begin
                    r_k   <= r_k + 2'd1;
                    r_acc <= qadd(r_acc, mul_q);
                    if (r_k == 2'd2) begin
                        r_k   <= '0;
                        r_acc <= '0;
                        if (r_i < 3) r_v[r_i[1:0]] <= qadd(r_acc, mul_q);
                        else r_w[2'(r_i - 4'd3)] <= qadd(r_acc, mul_q);
                        r_i <= r_i + 4'd1;
                        if (r_i == 4'd5) begin
                            r_i     <= '0;
                            r_state <= S_GAM;
                        end
                    end
                end
                S_GAM: begin
                    r_k   <= r_k + 2'd1;
                    r_acc <= qadd(r_acc, mul_q);
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_gam   <= qadd(t_q'({15'd0, r_lam}), qadd(r_acc, mul_q));
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (!r_dbusy) r_dbusy <= 1'b1;
                    else if (div_done) begin
                        r_dbusy <= 1'b0;
                        r_tmp   <= div_q;
                        r_state <= S_TSUB;
                    end
                end
                S_TSUB: begin
                    r_tmp   <= qsub(r_p[r_i], r_tmp);
                    r_state <= S_PDIV;
                end
                S_PDIV: begin
                    if (!r_dbusy) r_dbusy <= 1'b1;
                    else if (div_done) begin
                        r_dbusy   <= 1'b0;
                        r_p[r_i]  <= div_q;
                        r_i       <= r_i + 4'd1;
                        r_state   <= S_TDIV;
                        if (r_i == 4'd8) begin
                            r_i     <= '0;
                            r_state <= S_E;
                        end
                    end
                end
                S_E: begin
                    r_k   <= r_k + 2'd1;
                    r_acc <= qadd(r_acc, mul_q);
                    if (r_k == 2'd2) begin
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_e     <= qsub(qadd(r_err, qadd(r_acc, mul_q)), r_uf);
                        r_state <= S_G;
                    end
                end
                S_G: begin
                    r_k   <= r_k + 2'd1;
                    r_acc <= qadd(r_acc, mul_q);
                    if (r_k == 2'd2) begin
                        r_k   <= '0;
                        r_acc <= '0;
                        r_g[r_i[1:0]] <= qadd(r_acc, mul_q);
                        r_i   <= r_i + 4'd1;
                        if (r_i == 4'd2) begin
                            r_i     <= '0;
                            r_state <= S_GAIN;
                        end
                    end
                end
                S_GAIN: begin
                    r_gain[r_i[1:0]] <= qsub(r_gain[r_i[1:0]], mul_q);
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'd2) begin
                        r_i     <= '0;
                        r_state <= S_Y;
                    end
                end
                S_Y: begin
                    r_k   <= r_k + 2'd1;
                    r_acc <= qadd(r_acc, mul_q);
                    if (r_k == 2'd2) begin
                        r_k       <= '0;
                        r_acc     <= '0;
                        o_control <= qadd(r_acc, mul_q);
                        o_valid   <= 1'b1;
                        if (r_steps < 3'd4) r_steps <= r_steps + 3'd1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result is only shown while waiting for its transfer
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT)) else $error("valid outside output state");
    // step count saturates at four
    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= 3'd4) else $error("step count overflow");
    // no new item while busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("ready while busy");
endmodule

### sv/apid_div.sv
// restoring divider: (a * 2^16) / b, truncated toward zero, saturated
module apid_div
    import apid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_q   i_num,
    input  t_q   i_den,
    output logic o_done,
    output t_q   o_quo
);
    logic [47:0] r_dvd;
    logic [47:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_zero;
    logic        r_nsign;
    logic        r_nz;

    logic [47:0] num_mag;
    logic [32:0] trial;
    logic [32:0] sh;
    logic signed [63:0] sq;

    always_comb begin
        num_mag = {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'd0};
        sh      = {r_rem[31:0], r_dvd[47]};
        trial   = sh - {1'b0, r_den};
        sq      = r_neg ? -$signed({16'd0, r_quo}) : $signed({16'd0, r_quo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_dvd   <= num_mag;
                r_rem   <= '0;
                r_quo   <= '0;
                r_den   <= i_den[31] ? 32'(-i_den) : 32'(i_den);
                r_neg   <= i_num[31] ^ i_den[31];
                r_zero  <= (i_den == 0);
                r_nsign <= i_num[31];
                r_nz    <= (i_num != 0);
                r_cnt   <= 6'd48;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != 0) begin
                    r_dvd <= {r_dvd[46:0], 1'b0};
                    if (!trial[32]) begin
                        r_rem <= trial;
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= sh;
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                end else begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    if (r_zero) o_quo <= !r_nz ? '0 : (r_nsign ? QMIN : QMAX);
                    else o_quo <= sat64(sq);
                end
            end
        end
    end
endmodule

### tb/sv/adaptive_pid_gain_rls_update_tb.sv
`timescale 1ns / 100ps

module adaptive_pid_gain_rls_update_tb;
    import apid_pkg::*;

    // gain tuner model: filter tap, forgetting-factor rls update, control output
    class gain_tuner_scoreboard;
        logic [30:0] cov_diag;
        logic [16:0] lambda_q;
        t_q          tap_gain;
        t_q          gains[3];
        t_q          cov[9];
        t_q          u_hist;
        t_q          phi_hist[6];
        int          steps;
        t_q          control_q[$];
        int          mismatches;

        function new();
            cov_diag = COV_INIT_RST;
            lambda_q = FORGET_RST;
            tap_gain = FGAIN_RST;
            u_hist = '0;
            steps = 0;
            mismatches = 0;
            foreach (gains[i]) gains[i] = '0;
            foreach (phi_hist[i]) phi_hist[i] = '0;
            reload_cov();
        endfunction

        function void reload_cov();
            foreach (cov[i]) cov[i] = '0;
            for (int i = 0; i < 3; i++) cov[i*4] = t_q'({1'b0, cov_diag});
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_COV_INIT: begin
                    cov_diag = data[30:0];
                    reload_cov();
                end
                REG_FORGET_FACTOR: lambda_q = data[16:0];
                REG_FILTER_GAIN:   tap_gain = t_q'(data);
                default: ;
            endcase
        endfunction

        function t_q sat(logic signed [65:0] v);
            if (v > 66'sh7fffffff) return QMAX;
            if (v < -66'sh80000000) return QMIN;
            return t_q'(v[31:0]);
        endfunction

        // round half up: add 2^15, floor shift
        function t_q mul(t_q a, t_q b);
            logic signed [65:0] t;
            t = 66'(a) * 66'(b) + 66'sd32768;
            return sat(t >>> 16);
        endfunction

        function t_q sadd(t_q a, t_q b);
            return sat(66'(a) + 66'(b));
        endfunction

        function t_q ssub(t_q a, t_q b);
            return sat(66'(a) - 66'(b));
        endfunction

        // truncating division, zero divisor saturates by numerator sign
        function t_q div(t_q a, t_q b);
            logic signed [65:0] n;
            n = 66'(a) * 66'sd65536;
            if (b == 0) begin
                if (n > 0) return QMAX;
                if (n < 0) return QMIN;
                return '0;
            end
            return sat(n / 66'(b));
        endfunction

        function t_q dot3(t_q a0, t_q a1, t_q a2, t_q b0, t_q b1, t_q b2);
            t_q s;
            s = mul(a0, b0);
            s = sadd(s, mul(a1, b1));
            return sadd(s, mul(a2, b2));
        endfunction

        function void note_input(t_q err, t_q ei, t_q ed, t_q uprev);
            t_q phik[3], phi[3], v[3], w[3], g[3];
            t_q ufilt, lam, gam, e, y, t;
            phik[0] = err; phik[1] = ei; phik[2] = ed;
            u_hist = uprev;
            for (int j = 0; j < 3; j++) begin
                phi_hist[3+j] = phi_hist[j];
                phi_hist[j] = phik[j];
            end
            ufilt = mul(tap_gain, u_hist);
            for (int j = 0; j < 3; j++) phi[j] = mul(tap_gain, phi_hist[3+j]);
            if (steps >= 4) begin
                lam = t_q'({15'd0, lambda_q});
                for (int i = 0; i < 3; i++) begin
                    v[i] = dot3(cov[i*3], cov[i*3+1], cov[i*3+2], phi[0], phi[1], phi[2]);
                    w[i] = dot3(phi[0], phi[1], phi[2], cov[i], cov[3+i], cov[6+i]);
                end
                gam = sadd(lam, dot3(phi[0], phi[1], phi[2], v[0], v[1], v[2]));
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        t = div(mul(v[i], w[j]), gam);
                        cov[i*3+j] = div(ssub(cov[i*3+j], t), lam);
                    end
                e = ssub(sadd(err, dot3(phi[0], phi[1], phi[2],
                                        gains[0], gains[1], gains[2])), ufilt);
                for (int i = 0; i < 3; i++)
                    g[i] = dot3(cov[i*3], cov[i*3+1], cov[i*3+2], phi[0], phi[1], phi[2]);
                for (int i = 0; i < 3; i++) gains[i] = ssub(gains[i], mul(g[i], e));
            end
            y = dot3(phik[0], phik[1], phik[2], gains[0], gains[1], gains[2]);
            if (steps < 4) steps++;
            control_q.push_back(y);
        endfunction

        function void check_control(t_q got);
            t_q want;
            if (control_q.size() == 0) begin
                report_mismatch($sformatf("control %h with nothing expected", got));
                return;
            end
            want = control_q.pop_front();
            if (got !== want)
                report_mismatch($sformatf("control %h, expected %h", got, want));
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endfunction
    endclass

    localparam int IDLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_q          err_in;
    t_q          integ_in;
    t_q          deriv_in;
    t_q          uprev_in;
    logic        out_valid;
    logic        out_stall;
    t_q          control_out;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;

    gain_tuner_scoreboard sb;
    int send_idle_pct;     // chance per cycle the sender holds back
    int recv_stall_pct;    // chance per cycle the receiver stalls
    int hold_off_cycles;   // long receiver hold-off, counted in its own process
    int idle_cycles;
    bit timed_out;

    adaptive_pid_gain_rls_update DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_err            (err_in),
        .i_err_integral   (integ_in),
        .i_err_derivative (deriv_in),
        .i_prev_control   (uprev_in),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_control        (control_out),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        err_in = '0;
        integ_in = '0;
        deriv_in = '0;
        uprev_in = '0;
        cfg_we = 1'b0;
        cfg_idx = REG_COV_INIT;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk) begin
        if (hold_off_cycles > 0) begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // output transfers checked at the edge they happen
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_control(control_out);
    end

    // watchdog on cycles with no transfer on either side and no configuration write
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("adaptive_pid_gain_rls_update_tb failed");
            $finish;
        end
    end

    // one input transfer, with random sender gaps before it
    task automatic send_item(t_q e, t_q ei, t_q ed, t_q u);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        in_valid <= 1'b1;
        err_in <= e;
        integ_in <= ei;
        deriv_in <= ed;
        uprev_in <= u;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(e, ei, ed, u);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected result is checked, then longer than the worst-case item latency
    task automatic drain();
        while (sb.control_q.size() != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_q rand_q(int mode);
        case (mode)
            0: return t_q'($urandom);
            1: return t_q'($signed($urandom_range(131072)) - 65536);
            2: return t_q'($signed($urandom_range(16777216)) - 8388608);
            default: begin
                case ($urandom_range(3))
                    0: return QMAX;
                    1: return QMIN;
                    2: return '0;
                    default: return t_q'($urandom_range(65536));
                endcase
            end
        endcase
    endfunction

    // mostly modest magnitudes so the rls update stays meaningful
    task automatic random_items(int n);
        int m;
        for (int k = 0; k < n; k++) begin
            m = $urandom_range(9);
            m = (m < 5) ? 1 : (m < 8) ? 2 : (m == 8) ? 0 : 3;
            send_item(rand_q(m), rand_q(m), rand_q(m), rand_q(m));
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: steps before and after the update turns on, field extremes
        send_item(32'sd65536, 32'sd32768, -32'sd16384, 32'sd0);
        send_item(-32'sd65536, 32'sd131072, 32'sd6554, 32'sd65536);
        send_item(32'sd20000, -32'sd40000, 32'sd1000, -32'sd30000);
        send_item(32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send_item(32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536);
        send_item(QMAX, QMAX, QMAX, QMAX);
        send_item(QMIN, QMIN, QMIN, QMIN);
        send_item(QMAX, QMIN, 32'sd0, QMIN);
        send_item(32'sd1, -32'sd1, 32'sd65536, QMAX);
        send_item(-32'sd1, 32'sd1, -32'sd65536, 32'sd0);
        drain();

        // zero filter tap makes gamma equal lambda; lambda above one used as is
        write_cfg(REG_FILTER_GAIN, 32'd0);
        write_cfg(REG_FORGET_FACTOR, 32'h1ffff);
        send_item(32'sd65536, 32'sd1000, -32'sd1000, 32'sd500);
        send_item(-32'sd70000, 32'sd2000, 32'sd3000, 32'sd700);
        drain();
        // smallest nonzero lambda and widest cov diagonal
        write_cfg(REG_COV_INIT, 32'h7fffffff);
        write_cfg(REG_FORGET_FACTOR, 32'd1);
        write_cfg(REG_FILTER_GAIN, 32'h7fffffff);
        send_item(32'sd65536, -32'sd65536, 32'sd32768, 32'sd1);
        send_item(32'sd9, 32'sd300, -32'sd65536, 32'sd77);
        drain();
        // index past the register list is ignored
        write_cfg(2'd3, 32'h12345678);
        write_cfg(REG_COV_INIT, 32'd1);
        write_cfg(REG_FILTER_GAIN, 32'h80000000);
        send_item(32'sd4000, 32'sd5000, 32'sd6000, 32'sd7000);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off_cycles = 3000;
        random_items(4);
        drain();

        // random phases over several register settings and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            case (ph)
                0: begin
                    write_cfg(REG_COV_INIT, 32'd6554);
                    write_cfg(REG_FORGET_FACTOR, 32'd65536);
                    write_cfg(REG_FILTER_GAIN, 32'd65536);
                end
                1: write_cfg(REG_FORGET_FACTOR, 32'd64880);
                2: write_cfg(REG_FILTER_GAIN, 32'hffff0000);
                3: write_cfg(REG_COV_INIT, 32'd65536);
                default: write_cfg(2'($urandom_range(2)), $urandom);
            endcase
            random_items(52);
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (sb.mismatches == 0 && sb.control_q.size() == 0)
            $display("adaptive_pid_gain_rls_update_tb passed");
        else
            $display("adaptive_pid_gain_rls_update_tb failed");
        $finish;
    end
endmodule
